// File: sv/ssef_pkg.sv
// ---------------------------------------------------------------------------
// ssef_pkg : shared types and constants for the sobel sum edge filter
// beat layouts, window column type, cell opcodes and register indexes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssef_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // column index into a line, row counter runs to height + 1 during flush
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 4;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 4'd0,
        CFG_FRAME_HEIGHT = 4'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             is_drain;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_out_beat;

    // one window column: rows r-2, r-1, r
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    // one line store entry: the two rows above the current input row
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } t_line_pair;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_ZERO
    } t_cell_op;

endpackage

`default_nettype wire

// File: sv/ssef_line_store.sv
// ---------------------------------------------------------------------------
// ssef_line_store : line memory for the two rows above the input row
// one write and one registered read per cycle, write data forwarded on a hit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssef_line_store (
    input  wire logic                      i_clk,
    input  wire logic [ssef_pkg::COL_W-1:0] i_rd_addr,
    input  wire logic                      i_wr_en,
    input  wire logic [ssef_pkg::COL_W-1:0] i_wr_addr,
    input  wire ssef_pkg::t_line_pair       i_wr_data,
    output ssef_pkg::t_line_pair            o_rd_data
);
    import ssef_pkg::*;

    t_line_pair r_mem [MAX_WIDTH];
    t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/ssef_win_cell.sv
// ---------------------------------------------------------------------------
// ssef_win_cell : one column of the 3x3 window
// loads the column of its right neighbor, holds, or blanks to zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssef_win_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ssef_pkg::t_cell_op i_op,
    input  wire ssef_pkg::t_col     i_col,
    output ssef_pkg::t_col          o_col
);
    import ssef_pkg::*;

    t_col r_col;
    t_col n_col;

    always_comb begin
        case (i_op)
            CELL_HOLD: n_col = r_col;
            CELL_LOAD: n_col = i_col;
            CELL_ZERO: n_col = '0;
            default:   n_col = r_col;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// File: sv/sobel_sum_edge_filter_unit.sv
// ---------------------------------------------------------------------------
// sobel_sum_edge_filter_unit : streaming 3x3 sobel gx plus gy, clamped to 8 bits
// line store, two-cell window chain, edge adder and a two-entry output skid
// ---------------------------------------------------------------------------
// throughput: one pixel beat per cycle while the skid is empty, set by the single
//   read and write port of the line store, read one beat ahead at the next column
// output: the beat that closes a window, one row plus one pixel after the pixel
//   itself, registers its result onto o_out_data or into the skid behind a waiting beat
// reset: counters and window cleared, frame size 640 x 480, output empty;
//   line store is not cleared, unwritten entries are masked by row position
`timescale 1ns / 1ps
`default_nettype none

module sobel_sum_edge_filter_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire ssef_pkg::t_in_beat                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output ssef_pkg::t_out_beat                    o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ssef_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ssef_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ssef_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [WIDTH_W-1:0]  n_width;
    logic [HEIGHT_W-1:0] n_height;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_beat r_out;
    t_out_beat r_skid;
    logic      n_out_valid;
    logic      n_skid_valid;
    t_out_beat n_out;
    t_out_beat n_skid;

    logic       cfg_we;
    logic       cfg_hit;
    logic       in_acc;
    logic       restart;
    logic       row_ge1;
    logic       row_ge2;
    logic       col0;
    logic       emit;
    logic       last;
    logic       pop;
    logic       push;
    logic [PIX_W-1:0] pix;
    t_line_pair rd_pair;
    t_line_pair wr_pair;
    t_col       new_col;
    t_col       left_col;
    t_col       mid_col;
    t_col       right_col;
    t_cell_op   op_left;
    t_cell_op   op_mid;
    t_out_beat  res;

    logic [PIX_W+1:0] pos_sum;
    logic [PIX_W+1:0] neg_sum;
    logic [PIX_W+2:0] diff;
    logic [PIX_W-1:0] edge_val;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    // writes to an index outside the register list leave the frame alone
    assign cfg_hit     = cfg_we & (i_cfg_index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});
    assign o_in_stall  = r_skid_valid;
    assign in_acc      = i_in_valid & ~o_in_stall;

    // position decode
    assign row_ge1 = (r_row != '0);
    assign row_ge2 = (32'(r_row) >= 32'd2);
    assign col0    = (r_col == '0);
    assign emit    = row_ge1 & (~col0 | row_ge2);
    assign last    = col0 & (32'(r_row) == 32'(r_height) + 32'd1);
    assign restart = cfg_hit | (in_acc & last);

    assign pix = (i_in_data.is_drain || (32'(r_row) >= 32'(r_height))) ?
                 '0 : i_in_data.pixel_value;

    // incoming window column, rows above masked until written this frame
    always_comb begin
        new_col.top = row_ge2 ? rd_pair.upper  : '0;
        new_col.mid = row_ge1 ? rd_pair.middle : '0;
        new_col.bot = pix;
    end

    // at a line start the right column of the finished window is the border
    assign right_col = col0 ? '0 : new_col;

    // combined kernel: -2 -2 0 / -2 0 2 / 0 2 2
    always_comb begin
        pos_sum  = 10'(right_col.mid) + 10'(mid_col.bot) + 10'(right_col.bot);
        neg_sum  = 10'(left_col.top) + 10'(mid_col.top) + 10'(left_col.mid);
        diff     = {1'b0, pos_sum} - {1'b0, neg_sum};
        if (diff[PIX_W+2]) begin
            edge_val = '0;
        end else if (diff[PIX_W+1:PIX_W-1] != '0) begin
            edge_val = '1;
        end else begin
            edge_val = {diff[PIX_W-2:0], 1'b0};
        end
        res.edge_value = edge_val;
        res.frame_last = last;
    end

    // window chain control
    always_comb begin
        op_left = CELL_HOLD;
        op_mid  = CELL_HOLD;
        if (restart) begin
            op_left = CELL_ZERO;
            op_mid  = CELL_ZERO;
        end else if (in_acc) begin
            op_left = (col0 && row_ge1) ? CELL_ZERO : CELL_LOAD;
            op_mid  = CELL_LOAD;
        end
    end

    ssef_win_cell u_cell_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_left),
        .i_col   (mid_col),
        .o_col   (left_col)
    );

    ssef_win_cell u_cell_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_mid),
        .i_col   (new_col),
        .o_col   (mid_col)
    );

    // counters and frame size
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        if (cfg_we) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                if (i_cfg_data == '0) begin
                    n_width = WIDTH_W'(1);
                end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                    n_width = WIDTH_W'(MAX_WIDTH);
                end else begin
                    n_width = WIDTH_W'(i_cfg_data);
                end
            end else if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                if (i_cfg_data == '0) begin
                    n_height = HEIGHT_W'(1);
                end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                    n_height = HEIGHT_W'(MAX_HEIGHT);
                end else begin
                    n_height = HEIGHT_W'(i_cfg_data);
                end
            end
        end
        if (restart) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (32'(r_col) + 32'd1 >= 32'(r_width)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(RESET_WIDTH);
            r_height <= HEIGHT_W'(RESET_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    // line store is read one beat ahead so its data lines up with r_col
    always_comb begin
        wr_pair.upper  = rd_pair.middle;
        wr_pair.middle = pix;
    end

    ssef_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_addr (n_col),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_col),
        .i_wr_data (wr_pair),
        .o_rd_data (rd_pair)
    );

    // output register plus skid entry
    assign push = in_acc & emit;
    assign pop  = r_out_valid & ~i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = push;
                n_skid       = res;
            end else begin
                n_out_valid = push;
                n_out       = res;
            end
        end else if (!r_out_valid) begin
            n_out_valid = push;
            n_out       = res;
        end else if (push) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // skid entry only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // the beat carrying the final result restarts the frame
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last && !cfg_we) |=> (r_row == '0 && r_col == '0))
        else $error("frame did not restart after the final result");

    a_col_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(r_width))
        else $error("column counter beyond frame width");

    a_row_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) <= 32'(r_height) + 32'd1)
        else $error("row counter beyond the flush row");

endmodule

`default_nettype wire

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb : self-checking bench for sobel_sum_edge_filter_unit
// a beat-level tracker of the window and line stores predicts each result
// beat; directed frames cover register limits, drains and restarts, then
// random frames of random geometry run under random idling on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import ssef_pkg::*;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_HOLES,
        FRAME_OVERRUN
    } t_frame_shape;

    typedef enum int {
        PIX_NOISE,
        PIX_RAILS,
        PIX_RAMP
    } t_pixel_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sobel_sum_edge_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // tracked filter state
    logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    logic [PIX_W-1:0] win_px [3][3];
    int unsigned      geo_width;
    int unsigned      geo_height;
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      edges_done;

    t_out_beat        edge_due_q[$];
    t_out_beat        head_due;
    int unsigned      mismatch_count;
    int unsigned      beats_sent;
    bit               calm;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void restart_frame();
        row_pos    = 0;
        col_pos    = 0;
        edges_done = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win_px[i][j] = '0;
    endfunction

    function automatic void window_push(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                                        logic [PIX_W-1:0] bot);
        for (int i = 0; i < 3; i++) begin
            win_px[i][0] = win_px[i][1];
            win_px[i][1] = win_px[i][2];
        end
        win_px[0][2] = top;
        win_px[1][2] = mid;
        win_px[2][2] = bot;
    endfunction

    // gx plus gy folds into six taps of weight two
    function automatic logic [PIX_W-1:0] window_sobel();
        int acc;
        acc = 2 * (int'(win_px[1][2]) + int'(win_px[2][1]) + int'(win_px[2][2])
                 - int'(win_px[0][0]) - int'(win_px[0][1]) - int'(win_px[1][0]));
        if (acc > 255) return 8'hff;
        if (acc < 0) return 8'h00;
        return acc[PIX_W-1:0];
    endfunction

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
        if (v < 1) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic void track_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_FRAME_WIDTH) begin
            geo_width = clamp_dim(val, MAX_WIDTH);
            restart_frame();
        end else if (idx == CFG_FRAME_HEIGHT) begin
            geo_height = clamp_dim(val, MAX_HEIGHT);
            restart_frame();
        end
    endfunction

    function automatic void sobel_track_pixel(t_in_beat beat);
        int unsigned      r;
        int unsigned      c;
        int unsigned      ci;
        int unsigned      area;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] edge_v;
        bit               emit;
        t_out_beat        due;
        r      = row_pos;
        c      = col_pos;
        ci     = c % MAX_WIDTH;
        area   = geo_width * geo_height;
        emit   = 1'b0;
        edge_v = '0;
        pix    = (beat.is_drain || r >= geo_height) ? '0 : beat.pixel_value;
        // new row: a zero column closes the last window of the row before
        if (c == 0 && r >= 1) begin
            window_push('0, '0, '0);
            if (r >= 2) begin
                emit   = 1'b1;
                edge_v = window_sobel();
            end
        end
        top = (r >= 2) ? upper_line[ci] : '0;
        mid = (r >= 1) ? middle_line[ci] : '0;
        upper_line[ci]  = middle_line[ci];
        middle_line[ci] = pix;
        window_push(top, mid, pix);
        if (c >= 1 && r >= 1) begin
            emit   = 1'b1;
            edge_v = window_sobel();
        end
        c++;
        if (c >= geo_width) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        if (emit && edges_done < area) begin
            due.edge_value = edge_v;
            due.frame_last = (edges_done + 1 == area);
            edge_due_q.push_back(due);
            edges_done++;
            if (due.frame_last) restart_frame();
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (edge_due_q.size() == 0) begin
                $display("%0t: result beat with none due, actual edge %0d last %0b",
                         $time, o_out_data.edge_value, o_out_data.frame_last);
                mismatch_count++;
            end else begin
                head_due = edge_due_q.pop_front();
                if (o_out_data.edge_value !== head_due.edge_value) begin
                    $display("%0t: edge_value expected %0d actual %0d",
                             $time, head_due.edge_value, o_out_data.edge_value);
                    mismatch_count++;
                end
                if (o_out_data.frame_last !== head_due.frame_last) begin
                    $display("%0t: frame_last expected %0b actual %0b",
                             $time, head_due.frame_last, o_out_data.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // random output back-pressure in bursts while not calm
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(t_pixel_style style);
        case (style)
            PIX_RAILS: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            PIX_RAMP:  return PIX_W'($urandom_range(100, 131));
            default:   return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input t_in_beat beat);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sobel_track_pixel(beat);
        beats_sent++;
    endtask

    // drop valid and let every due result and the pipeline drain
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (edge_due_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        track_register(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_partial(input int unsigned count, input t_pixel_style style);
        t_in_beat beat;
        for (int unsigned i = 0; i < count; i++) begin
            beat.pixel_value = pick_pixel(style);
            beat.is_drain    = 1'b0;
            send_pixel(beat);
        end
    endtask

    // one full frame followed by width+1 flush beats
    task automatic send_frame(input t_frame_shape shape, input t_pixel_style style);
        t_in_beat    beat;
        int unsigned area;
        area = geo_width * geo_height;
        for (int unsigned i = 0; i < area; i++) begin
            beat.pixel_value = pick_pixel(style);
            beat.is_drain    = (shape == FRAME_HOLES) && (i % 3 == 0);
            send_pixel(beat);
        end
        for (int unsigned i = 0; i <= geo_width; i++) begin
            beat.pixel_value = PIX_W'($urandom_range(0, 255));
            beat.is_drain    = (shape != FRAME_OVERRUN) || ($urandom_range(0, 3) == 0);
            send_pixel(beat);
        end
    endtask

    task automatic test_reset_geometry();
        // reset width of 640, one row and a bit, restarted by the next write
        send_partial(RESET_WIDTH + 2, PIX_NOISE);
    endtask

    task automatic test_smallest_frames();
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '0);
        send_frame(FRAME_CLEAN, PIX_NOISE);
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
        send_frame(FRAME_CLEAN, PIX_NOISE);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
        send_frame(FRAME_CLEAN, PIX_NOISE);
    endtask

    task automatic test_clamp_rails();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
        // back to back frames, the second starts right after frame_last
        send_frame(FRAME_CLEAN, PIX_RAILS);
        send_frame(FRAME_CLEAN, PIX_RAILS);
        send_frame(FRAME_CLEAN, PIX_RAMP);
    endtask

    task automatic test_dimension_limits();
        write_reg(CFG_FRAME_WIDTH, '1);
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
        // the first result only appears once the clamped line has wrapped
        send_partial(MAX_WIDTH + 2, PIX_NOISE);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_FRAME_HEIGHT, '1);
        send_partial(5, PIX_NOISE);
    endtask

    task automatic test_unused_index();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
        // a frame in progress carries on across writes to unused indexes
        send_partial(4, PIX_NOISE);
        write_reg(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)), '1);
        write_reg(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)), '0);
        send_frame(FRAME_CLEAN, PIX_NOISE);
    endtask

    task automatic test_drain_cases();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(4));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
        send_frame(FRAME_HOLES, PIX_NOISE);
        send_frame(FRAME_OVERRUN, PIX_NOISE);
    endtask

    task automatic test_abandoned_frame();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(5));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(4));
        send_partial(7, PIX_NOISE);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(5));
        send_frame(FRAME_CLEAN, PIX_NOISE);
    endtask

    task automatic test_random_frames();
        int unsigned  goal;
        int unsigned  w;
        int unsigned  h;
        int unsigned  act;
        bit           must_restart;
        t_pixel_style style;
        goal         = beats_sent + 250;
        must_restart = 1'b1;
        while (beats_sent < goal) begin
            calm = (beats_sent + 100 >= goal);
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(13, 64);
                h = $urandom_range(1, 4);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
            act = $urandom_range(0, 9);
            if (must_restart || act < 5) begin
                write_reg(CFG_FRAME_WIDTH,
                          ($urandom_range(0, 15) == 0) ? '0 : CFG_DATA_W'(w));
                write_reg(CFG_FRAME_HEIGHT,
                          ($urandom_range(0, 15) == 0) ? '0 : CFG_DATA_W'(h));
            end else if (act == 5) begin
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
            end else if (act == 6) begin
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
            end else if (act == 7) begin
                write_reg(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
            end
            must_restart = 1'b0;
            style = t_pixel_style'($urandom_range(0, 2));
            act   = $urandom_range(0, 9);
            if (act < 6) begin
                send_frame(FRAME_CLEAN, style);
            end else if (act == 6) begin
                send_frame(FRAME_HOLES, style);
            end else if (act == 7) begin
                send_frame(FRAME_OVERRUN, style);
            end else begin
                // broken frame, cut off and restarted by a register write
                send_partial($urandom_range(0, geo_width * geo_height - 1), style);
                must_restart = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        calm           = 1'b0;
        mismatch_count = 0;
        beats_sent     = 0;
        geo_width      = RESET_WIDTH;
        geo_height     = RESET_HEIGHT;
        restart_frame();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_smallest_frames();
        test_clamp_rails();
        test_dimension_limits();
        test_unused_index();
        test_drain_cases();
        test_abandoned_frame();
        test_random_frames();

        settle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && edge_due_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
